[hdl/quaternion_arithmetic_unit_macros.svh]
// Assertion helpers for the checker file of the quaternion unit.
`ifndef QUATERNION_ARITHMETIC_UNIT_MACROS_SVH
`define QUATERNION_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define QAU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only outside reset.
`define QAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/qau_pkg.sv]
package qau_pkg;

  // Number format.
  localparam int FRAC_BITS  = 14;
  localparam int GUARD_BITS = 8;
  localparam int COMP_W     = 16;

  // Datapath widths derived from the format.
  localparam int PROD_W  = 2 * COMP_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int CLIP_W  = SUM_W + 1;
  localparam int SQ_W    = PROD_W + 1;
  localparam int ROOT_W  = (SQ_W + 2 * GUARD_BITS + 1) / 2;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int QUOT_W  = COMP_W;
  localparam int NUM_W   = COMP_W + FRAC_BITS + GUARD_BITS + 1;
  localparam int DIV_W   = (NUM_W > ROOT_W + QUOT_W) ? NUM_W : ROOT_W + QUOT_W;
  localparam int LATENCY = 2 + ROOT_W + 1 + QUOT_W + 1;

  localparam logic signed [CLIP_W-1:0] RND_HALF = CLIP_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [CLIP_W-1:0] COMP_MAX = CLIP_W'((1 <<< (COMP_W - 1)) - 1);
  localparam logic signed [CLIP_W-1:0] COMP_MIN = CLIP_W'(-(1 <<< (COMP_W - 1)));

  typedef enum logic [1:0] {
    CMD_MUL  = 2'd0,
    CMD_CONJ = 2'd1,
    CMD_NORM = 2'd2,
    CMD_CMP  = 2'd3
  } cmd_t;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    cmd_t              command;
    logic signed [15:0] a_w;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] b_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] r_w;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [15:0] r_z;
    logic               equal;
    logic               saturated;
  } out_t;

  // Sideband that rides along the root and divide pipelines.
  typedef struct packed {
    cmd_t            cmd;
    logic            zero;
    comp_t [3:0]     a;
    out_t            early;
  } side_t;

  typedef struct packed {
    comp_t val;
    logic  sat;
  } clip_t;

  // Clip a wide signed value to the component range.
  function automatic clip_t clip_val(input logic signed [CLIP_W-1:0] v);
    clip_t c;
    if (v > COMP_MAX) begin
      c.val = COMP_MAX[COMP_W-1:0];
      c.sat = 1'b1;
    end else if (v < COMP_MIN) begin
      c.val = COMP_MIN[COMP_W-1:0];
      c.sat = 1'b1;
    end else begin
      c.val = v[COMP_W-1:0];
      c.sat = 1'b0;
    end
    return c;
  endfunction

  // Round to nearest, ties toward plus infinity, then clip.
  function automatic clip_t round_prod(input logic signed [CLIP_W-1:0] s);
    logic signed [CLIP_W-1:0] t;
    t = s + RND_HALF;
    return clip_val(t >>> FRAC_BITS);
  endfunction

  function automatic logic signed [CLIP_W-1:0] sx_prod(input logic signed [PROD_W-1:0] p);
    return CLIP_W'(p);
  endfunction

endpackage

[hdl/qau_front.sv]
module qau_front
  import qau_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  in_t               in_item,
  output logic              sd_valid,
  output side_t             sd,
  output logic [SQ_W-1:0]   sd_sq
);

  comp_t a_in [4];
  comp_t b_in [4];

  logic                     v1_r;
  cmd_t                     cmd1_r;
  comp_t                    a1_r [4];
  logic                     eq1_r;
  logic signed [PROD_W-1:0] p_r [4][4];
  logic signed [PROD_W-1:0] sq_r [4];

  logic                     v2_r;
  side_t                    side2_r;
  logic [SQ_W-1:0]          sq2_r;

  logic signed [CLIP_W-1:0] sum [4];
  clip_t                    rnd [4];
  clip_t                    neg [3];
  logic [SQ_W-1:0]          sq_nxt;
  out_t                     early_nxt;
  side_t                    side_nxt;

  // Unpack the input transfer into component arrays.
  always_comb begin
    a_in[0] = in_item.a_w;
    a_in[1] = in_item.a_x;
    a_in[2] = in_item.a_y;
    a_in[3] = in_item.a_z;
    b_in[0] = in_item.b_w;
    b_in[1] = in_item.b_x;
    b_in[2] = in_item.b_y;
    b_in[3] = in_item.b_z;
  end

  // Stage one: all cross products, squares and the equality test.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    cmd1_r <= in_item.command;
    eq1_r  <= (a_in[0] == b_in[0]) && (a_in[1] == b_in[1]) &&
              (a_in[2] == b_in[2]) && (a_in[3] == b_in[3]);
    for (int i = 0; i < 4; i++) begin
      a1_r[i] <= a_in[i];
      sq_r[i] <= PROD_W'(a_in[i]) * PROD_W'(a_in[i]);
      for (int j = 0; j < 4; j++) begin
        p_r[i][j] <= PROD_W'(a_in[i]) * PROD_W'(b_in[j]);
      end
    end
  end

  // Stage two: Hamilton sums, rounding and the results that need no root.
  always_comb begin
    sum[0] = sx_prod(p_r[0][0]) - sx_prod(p_r[1][1]) - sx_prod(p_r[2][2]) - sx_prod(p_r[3][3]);
    sum[1] = sx_prod(p_r[0][1]) + sx_prod(p_r[1][0]) + sx_prod(p_r[2][3]) - sx_prod(p_r[3][2]);
    sum[2] = sx_prod(p_r[0][2]) - sx_prod(p_r[1][3]) + sx_prod(p_r[2][0]) + sx_prod(p_r[3][1]);
    sum[3] = sx_prod(p_r[0][3]) + sx_prod(p_r[1][2]) - sx_prod(p_r[2][1]) + sx_prod(p_r[3][0]);
    for (int i = 0; i < 4; i++) begin
      rnd[i] = round_prod(sum[i]);
    end
    for (int i = 0; i < 3; i++) begin
      neg[i] = clip_val(-CLIP_W'(a1_r[i+1]));
    end
    sq_nxt = SQ_W'($unsigned(sq_r[0])) + SQ_W'($unsigned(sq_r[1])) +
             SQ_W'($unsigned(sq_r[2])) + SQ_W'($unsigned(sq_r[3]));
  end

  always_comb begin
    early_nxt = '0;
    unique case (cmd1_r)
      CMD_MUL: begin
        early_nxt.r_w       = rnd[0].val;
        early_nxt.r_x       = rnd[1].val;
        early_nxt.r_y       = rnd[2].val;
        early_nxt.r_z       = rnd[3].val;
        early_nxt.saturated = rnd[0].sat | rnd[1].sat | rnd[2].sat | rnd[3].sat;
      end
      CMD_CONJ: begin
        early_nxt.r_w       = a1_r[0];
        early_nxt.r_x       = neg[0].val;
        early_nxt.r_y       = neg[1].val;
        early_nxt.r_z       = neg[2].val;
        early_nxt.saturated = neg[0].sat | neg[1].sat | neg[2].sat;
      end
      CMD_NORM: begin
        early_nxt = '0;
      end
      CMD_CMP: begin
        early_nxt.equal = eq1_r;
      end
      default: begin
        early_nxt = '0;
      end
    endcase
    side_nxt.cmd   = cmd1_r;
    side_nxt.zero  = (sq_nxt == '0);
    for (int i = 0; i < 4; i++) begin
      side_nxt.a[i] = a1_r[i];
    end
    side_nxt.early = early_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    side2_r <= side_nxt;
    sq2_r   <= sq_nxt;
  end

  assign sd_valid = v2_r;
  assign sd       = side2_r;
  assign sd_sq    = sq2_r;

endmodule

[hdl/qau_sqrt.sv]
module qau_sqrt
  import qau_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  side_t             in_side,
  input  logic [SQ_W-1:0]   in_sq,
  output logic              out_valid,
  output side_t             out_side,
  output logic [ROOT_W-1:0] out_root
);

  // One root bit per stage, restoring digit-by-digit square root.
  logic              v_r    [ROOT_W];
  side_t             side_r [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              v_in;
    side_t             side_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;

    if (k == 0) begin : g_first
      // The radicand carries the guard bits as zeros below the sum of squares.
      assign v_in    = in_valid;
      assign side_in = in_side;
      assign rad_in  = RAD_W'({in_sq, {(2 * GUARD_BITS){1'b0}}});
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign side_in = side_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign cur   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      side_r[k] <= side_in;
      rad_r[k]  <= rad_in << 2;
      if (cur >= trial) begin
        rem_r[k]  <= cur - trial;
        root_r[k] <= {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r[k]  <= cur;
        root_r[k] <= {root_in[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];

endmodule

[hdl/qau_div.sv]
module qau_div
  import qau_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  side_t                  in_side,
  input  logic [ROOT_W-1:0]      in_root,
  output logic                   out_valid,
  output side_t                  out_side,
  output logic [3:0][QUOT_W-1:0] out_quot,
  output logic [3:0]             out_big
);

  logic              pv_r;
  side_t             pside_r;
  logic [ROOT_W-1:0] pm_r;
  logic [DIV_W-1:0]  prem_r [4];
  logic [3:0]        pbig_r;

  logic [COMP_W-1:0] mag  [4];
  logic [NUM_W-1:0]  num  [4];

  logic              v_r    [QUOT_W];
  side_t             side_r [QUOT_W];
  logic [ROOT_W-1:0] m_r    [QUOT_W];
  logic [3:0]        big_r  [QUOT_W];
  logic [DIV_W-1:0]  rem_r  [QUOT_W][4];
  logic [QUOT_W-1:0] q_r    [QUOT_W][4];

  // Prepare stage: magnitude, scaled numerator with half divisor, overflow test.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = in_side.a[i][COMP_W-1] ? COMP_W'(-in_side.a[i]) : COMP_W'(in_side.a[i]);
      num[i] = (NUM_W'(mag[i]) << (FRAC_BITS + GUARD_BITS)) + NUM_W'(in_root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    pside_r <= in_side;
    pm_r    <= in_root;
    for (int i = 0; i < 4; i++) begin
      prem_r[i] <= DIV_W'(num[i]);
      pbig_r[i] <= DIV_W'(num[i]) >= (DIV_W'(in_root) << QUOT_W);
    end
  end

  // One quotient bit per stage for all four lanes, restoring division.
  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    localparam int BIT = QUOT_W - 1 - k;
    logic              v_in;
    side_t             side_in;
    logic [ROOT_W-1:0] m_in;
    logic [3:0]        big_in;
    logic [DIV_W-1:0]  rem_in [4];
    logic [QUOT_W-1:0] q_in   [4];
    logic [DIV_W-1:0]  dsh;

    if (k == 0) begin : g_first
      assign v_in    = pv_r;
      assign side_in = pside_r;
      assign m_in    = pm_r;
      assign big_in  = pbig_r;
      for (genvar i = 0; i < 4; i++) begin : g_lane
        assign rem_in[i] = prem_r[i];
        assign q_in[i]   = '0;
      end
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign side_in = side_r[k-1];
      assign m_in    = m_r[k-1];
      assign big_in  = big_r[k-1];
      for (genvar i = 0; i < 4; i++) begin : g_lane
        assign rem_in[i] = rem_r[k-1][i];
        assign q_in[i]   = q_r[k-1][i];
      end
    end

    assign dsh = DIV_W'(m_in) << BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      side_r[k] <= side_in;
      m_r[k]    <= m_in;
      big_r[k]  <= big_in;
      for (int i = 0; i < 4; i++) begin
        if (rem_in[i] >= dsh) begin
          rem_r[k][i] <= rem_in[i] - dsh;
          q_r[k][i]   <= q_in[i] | (QUOT_W'(1) << BIT);
        end else begin
          rem_r[k][i] <= rem_in[i];
          q_r[k][i]   <= q_in[i];
        end
      end
    end
  end

  assign out_valid = v_r[QUOT_W-1];
  assign out_side  = side_r[QUOT_W-1];
  assign out_big   = big_r[QUOT_W-1];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      out_quot[i] = q_r[QUOT_W-1][i];
    end
  end

endmodule

[hdl/quaternion_arithmetic_unit.sv]
// From start transfer to out_valid strobe, the same for every command: two product
// stages, one per root bit, divider prepare, one per quotient bit, output register.
// Throughput: one transfer per cycle; busy stays low since every stage advances
// each cycle and results are never held off.
// Reset: synchronous, active low; clears the valid bits of every stage, payload
// registers are not reset.
module quaternion_arithmetic_unit
  import qau_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  logic                   f_valid;
  side_t                  f_side;
  logic [SQ_W-1:0]        f_sq;
  logic                   s_valid;
  side_t                  s_side;
  logic [ROOT_W-1:0]      s_root;
  logic                   d_valid;
  side_t                  d_side;
  logic [3:0][QUOT_W-1:0] d_quot;
  logic [3:0]             d_big;

  logic signed [CLIP_W-1:0] qv  [4];
  clip_t                    nc  [4];
  out_t                     out_nxt;
  logic                     out_valid_r;
  out_t                     out_data_r;

  assign busy = 1'b0;

  qau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_item  (in_data),
    .sd_valid (f_valid),
    .sd       (f_side),
    .sd_sq    (f_sq)
  );

  qau_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_side   (f_side),
    .in_sq     (f_sq),
    .out_valid (s_valid),
    .out_side  (s_side),
    .out_root  (s_root)
  );

  qau_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_side   (s_side),
    .in_root   (s_root),
    .out_valid (d_valid),
    .out_side  (d_side),
    .out_quot  (d_quot),
    .out_big   (d_big)
  );

  // Apply signs to the quotients and clip; an overflowed quotient counts as 2^16.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qv[i] = d_big[i] ? (CLIP_W'(1) <<< QUOT_W) : CLIP_W'(d_quot[i]);
      nc[i] = clip_val(d_side.a[i][COMP_W-1] ? -qv[i] : qv[i]);
    end
  end

  // Pick the normalize result or the one settled in the front stages.
  always_comb begin
    out_nxt = d_side.early;
    if (d_side.cmd == CMD_NORM) begin
      out_nxt.equal = 1'b0;
      if (d_side.zero) begin
        out_nxt.r_w       = d_side.a[0];
        out_nxt.r_x       = d_side.a[1];
        out_nxt.r_y       = d_side.a[2];
        out_nxt.r_z       = d_side.a[3];
        out_nxt.saturated = 1'b0;
      end else begin
        out_nxt.r_w       = nc[0].val;
        out_nxt.r_x       = nc[1].val;
        out_nxt.r_y       = nc[2].val;
        out_nxt.r_z       = nc[3].val;
        out_nxt.saturated = nc[0].sat | nc[1].sat | nc[2].sat | nc[3].sat;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/qau_checker.sv]
`include "quaternion_arithmetic_unit_macros.svh"

module qau_checker
  import qau_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input out_t out_data
);

  logic        accepted;
  logic [63:0] out_quat;
  logic        clean_cmp;

  assign accepted  = start && !busy;
  assign out_quat  = {out_data.r_w, out_data.r_x, out_data.r_y, out_data.r_z};
  assign clean_cmp = (out_quat == '0) && !out_data.saturated;

  // The unit never refuses a transfer.
  `QAU_ASSERT_IMP(a_never_busy, 1'b1, !busy, "busy raised")

  // Every result strobe traces back to an accepted transfer.
  `QAU_ASSERT_IMP(a_out_has_source, out_valid, $past(accepted, LATENCY), "spurious result")

  // Every accepted transfer yields a result after the fixed latency.
  `QAU_ASSERT_NEXT(a_accept_gives_out, accepted, ##(LATENCY-1) out_valid, "result lost")

  // A compare hit reports a zero quaternion and no saturation.
  `QAU_ASSERT_IMP(a_equal_clean, out_valid && out_data.equal, clean_cmp, "compare not clean")

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (.*);

[test/testbench.sv]
module testbench;
  import qau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_data;
  logic out_valid;
  out_t out_data;

  out_t expected_results[$];
  int mismatch_count;
  int cycle_count;
  int send_idle_pct;

  quaternion_arithmetic_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Saturate a wide signed value to the component range.
  function automatic logic signed [15:0] sat16(input longint v, inout logic sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Round a product sum to nearest, ties toward plus infinity.
  function automatic logic signed [15:0] round_sum(input longint s, inout logic sat);
    longint t;
    t = (s + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    return sat16(t, sat);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Divide one component by the magnitude, rounding ties away from zero.
  function automatic logic signed [15:0] scale_comp(input longint c, input longint unsigned m,
                                                    inout logic sat);
    longint unsigned mag;
    longint unsigned q;
    longint r;
    mag = (c < 0) ? -c : c;
    q = ((mag << (FRAC_BITS + GUARD_BITS)) + (m >> 1)) / m;
    if (q > 65536) q = 65536;
    r = q;
    if (c < 0) r = -r;
    return sat16(r, sat);
  endfunction

  function automatic out_t quat_result(input in_t it);
    out_t r;
    longint aw, ax, ay, az, bw, bx, by, bz;
    longint unsigned s, m;
    logic sat;
    aw = it.a_w; ax = it.a_x; ay = it.a_y; az = it.a_z;
    bw = it.b_w; bx = it.b_x; by = it.b_y; bz = it.b_z;
    r = '0;
    sat = 1'b0;
    case (it.command)
      CMD_MUL: begin
        r.r_w = round_sum(aw * bw - ax * bx - ay * by - az * bz, sat);
        r.r_x = round_sum(aw * bx + ax * bw + ay * bz - az * by, sat);
        r.r_y = round_sum(aw * by - ax * bz + ay * bw + az * bx, sat);
        r.r_z = round_sum(aw * bz + ax * by - ay * bx + az * bw, sat);
      end
      CMD_CONJ: begin
        r.r_w = it.a_w;
        r.r_x = sat16(-ax, sat);
        r.r_y = sat16(-ay, sat);
        r.r_z = sat16(-az, sat);
      end
      CMD_NORM: begin
        s = aw * aw + ax * ax + ay * ay + az * az;
        if (s == 0) begin
          r.r_w = it.a_w; r.r_x = it.a_x; r.r_y = it.a_y; r.r_z = it.a_z;
        end else begin
          m = int_sqrt(s << (2 * GUARD_BITS));
          r.r_w = scale_comp(aw, m, sat);
          r.r_x = scale_comp(ax, m, sat);
          r.r_y = scale_comp(ay, m, sat);
          r.r_z = scale_comp(az, m, sat);
        end
      end
      default: begin
        r.equal = (aw == bw) && (ax == bx) && (ay == by) && (az == bz);
      end
    endcase
    r.saturated = sat;
    return r;
  endfunction

  // Send one item; the transfer happens at the rising edge with start high and busy low.
  // Start stays high on return so that the next item can follow without a gap.
  task automatic send_item(input in_t it);
    while (($urandom_range(99, 0)) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(quat_result(it));
    @(negedge clk);
  endtask

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data !== exp_r) begin
          $display("%0t: expected %h, actual %h", $time, exp_r, out_data);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(5, 0))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(32, 0)) - 16);
      3: return 16'(int'($urandom_range(32768, 0)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t mk(input cmd_t c, input logic signed [15:0] w, x, y, z,
                             input logic signed [15:0] bw, bx, by, bz);
    in_t it;
    it.command = c;
    it.a_w = w; it.a_x = x; it.a_y = y; it.a_z = z;
    it.b_w = bw; it.b_x = bx; it.b_y = by; it.b_z = bz;
    return it;
  endfunction

  // Extremes and special cases of every command.
  task automatic test_directed();
    send_item(mk(CMD_MUL, 16'sh4000, 0, 0, 0, 16'sh4000, 0, 0, 0));
    send_item(mk(CMD_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
    send_item(mk(CMD_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
    send_item(mk(CMD_MUL, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000));
    send_item(mk(CMD_MUL, 1, 0, 0, 0, 16'sh2000, 0, 0, 0));
    send_item(mk(CMD_MUL, -1, 0, 0, 0, 16'sh2000, 0, 0, 0));
    send_item(mk(CMD_CONJ, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0, 0));
    send_item(mk(CMD_CONJ, 16'sh7fff, 16'sh7fff, 0, -1, 0, 0, 0, 0));
    send_item(mk(CMD_NORM, 0, 0, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff));
    send_item(mk(CMD_NORM, 1, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(CMD_NORM, 0, -1, 0, 0, 0, 0, 0, 0));
    send_item(mk(CMD_NORM, 16'sh8000, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(CMD_NORM, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0, 0));
    send_item(mk(CMD_NORM, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0));
    send_item(mk(CMD_NORM, 16'sh4000, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(CMD_NORM, 3, -4, 0, 0, 0, 0, 0, 0));
    send_item(mk(CMD_CMP, 5, 6, 7, 8, 5, 6, 7, 8));
    send_item(mk(CMD_CMP, 5, 6, 7, 8, 5, 6, 7, 9));
    send_item(mk(CMD_CMP, 16'sh8000, 16'sh7fff, 0, -1, 16'sh8000, 16'sh7fff, 0, -1));
    send_item(mk(CMD_CMP, 16'sh8000, 0, 0, 0, 16'sh7fff, 0, 0, 0));
  endtask

  // Random items of every command; compares are often made equal on purpose.
  task automatic test_random(input int count);
    in_t it;
    repeat (count) begin
      it.command = cmd_t'($urandom_range(3, 0));
      it.a_w = rand_comp(); it.a_x = rand_comp(); it.a_y = rand_comp(); it.a_z = rand_comp();
      it.b_w = rand_comp(); it.b_x = rand_comp(); it.b_y = rand_comp(); it.b_z = rand_comp();
      if (it.command == CMD_CMP && $urandom_range(1, 0)) begin
        it.b_w = it.a_w; it.b_x = it.a_x; it.b_y = it.a_y;
        it.b_z = $urandom_range(1, 0) ? it.a_z : it.a_z ^ (16'sh1 << $urandom_range(15, 0));
      end
      send_item(it);
    end
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    mismatch_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    start = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 24;
    test_directed();
    test_random(600);
    send_idle_pct = 64;
    test_random(600);
    send_idle_pct = 0;
    test_random(630);
    start <= 1'b0;
    wait_drained();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/qau_pkg.sv
hdl/qau_front.sv
hdl/qau_sqrt.sv
hdl/qau_div.sv
hdl/quaternion_arithmetic_unit.sv
hdl/qau_checker.sv
test/testbench.sv
